/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lch_pkg.sv */
`default_nettype none

package lch_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_THRESHOLD   = 1'b0;
    localparam logic CFG_REPLACEMENT = 1'b1;

    localparam logic [8:0] THRESHOLD_RESET   = 9'd256;
    localparam logic [8:0] REPLACEMENT_RESET = 9'd192;
    localparam logic [8:0] LIGHTNESS_FULL    = 9'd256;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } lch_pixel_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       was_changed;
    } lch_result_t;

    // Side data carried alongside the arithmetic
    typedef struct packed {
        lch_pixel_t pixel;
        logic       changed;
        logic       gray;
        logic [8:0] repl;
    } lch_carry_t;

    // Piece of the hue-to-channel curve
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } lch_seg_t;

endpackage

`default_nettype wire

/* rtl/lightness_clamp_hsl_core.sv */
// Lightness clamp on an RGB pixel stream.
// Input channel: pixel (red, green, blue) with pixel_valid / pixel_stall.
// Output channel: result (red, green, blue, was_changed) with
// result_valid / result_stall. A request moves when valid is high and
// stall is low at a rising edge of clk.
// Configuration: cfg_write_en, cfg_index (0 = threshold, 1 = replacement)
// and cfg_data; write only while the pipeline is empty.
// Registers in order: one prepare stage, FRACTION_BITS + 1 restoring-division
// stages (hue and saturation side by side, one quotient bit per stage), three
// stages for lightness mix and channel curve, and the output register.
// Throughput is one pixel per cycle; the pipeline takes a new request
// every cycle while the output is not stalled.
// When result_stall holds a waiting result, the whole pipeline freezes and
// pixel_stall is raised; nothing is lost or repeated.
// Reset empties the pipeline and loads threshold 256 and replacement 192.
`default_nettype none
`include "assert_macros.svh"

module lightness_clamp_hsl_core
    import lch_pkg::*;
#(
    parameter int FRACTION_BITS = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    input  wire lch_pixel_t  pixel,
    output logic             result_valid,
    input  wire logic        result_stall,
    output lch_result_t      result
);

    localparam int FB    = FRACTION_BITS;
    localparam int TW    = FB + 1;
    localparam int NDIV  = FB + 1;
    localparam int ONE_I = 1 << FB;
    localparam logic [TW-1:0] FX_ONE        = TW'(ONE_I);
    localparam logic [TW-1:0] FX_HALF       = TW'(ONE_I / 2);
    localparam logic [TW-1:0] FX_THIRD      = TW'((ONE_I + 1) / 3);
    localparam logic [TW-1:0] FX_SIXTH      = TW'((ONE_I + 3) / 6);
    localparam logic [TW-1:0] FX_TWO_THIRDS = TW'((2 * ONE_I + 1) / 3);

    logic [8:0] thr_reg;
    logic [8:0] repl_reg;
    logic       advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            repl_reg <= REPLACEMENT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_THRESHOLD:   thr_reg  <= cfg_data;
                CFG_REPLACEMENT: repl_reg <= cfg_data;
                default:         thr_reg  <= thr_reg;
            endcase
        end
    end

    // Freeze everything while a finished result waits
    assign advance     = !(result_valid && result_stall);
    assign pixel_stall = !advance;

    // ---------------- prepare stage ----------------
    logic [7:0]  mx, mn, dd, den;
    logic [8:0]  sum;
    logic [10:0] d6;
    logic [11:0] num;
    logic        do_chg;
    logic [8:0]  repl_sat;

    always_comb
    begin
        mx = (pixel.red_in > pixel.green_in) ? pixel.red_in : pixel.green_in;
        if (pixel.blue_in > mx)
            mx = pixel.blue_in;
        mn = (pixel.red_in < pixel.green_in) ? pixel.red_in : pixel.green_in;
        if (pixel.blue_in < mn)
            mn = pixel.blue_in;
        sum    = {1'b0, mx} + {1'b0, mn};
        do_chg = {1'b0, sum, 7'b0} >= (17'(thr_reg) * 17'd255);
        repl_sat = (repl_reg > LIGHTNESS_FULL) ? LIGHTNESS_FULL : repl_reg;
        dd  = mx - mn;
        d6  = {1'b0, dd, 2'b0} + {2'b0, dd, 1'b0};
        // hue numerator, red wins ties over green over blue
        if (mx == pixel.red_in)
            num = {4'b0, pixel.green_in} - {4'b0, pixel.blue_in}
                + ((pixel.green_in < pixel.blue_in) ? {1'b0, d6} : 12'd0);
        else if (mx == pixel.green_in)
            num = {4'b0, pixel.blue_in} - {4'b0, pixel.red_in} + {3'b0, dd, 1'b0};
        else
            num = {4'b0, pixel.red_in} - {4'b0, pixel.green_in} + {2'b0, dd, 2'b0};
        den = (sum > 9'd255) ? 8'(10'd510 - {1'b0, sum}) : sum[7:0];
    end

    // ---------------- division pipeline ----------------
    logic             dv_valid_reg [NDIV+1];
    lch_carry_t       dv_carry_reg [NDIV+1];
    logic [10:0]      hrem_reg     [NDIV+1];
    logic [10:0]      hdiv_reg     [NDIV+1];
    logic [TW-1:0]    hq_reg       [NDIV+1];
    logic [7:0]       srem_reg     [NDIV+1];
    logic [7:0]       sdiv_reg     [NDIV+1];
    logic [TW-1:0]    sq_reg       [NDIV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (advance)
            dv_valid_reg[0] <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_carry_reg[0] <= '{pixel: pixel, changed: do_chg, gray: (mx == mn),
                                 repl: repl_sat};
            hrem_reg[0] <= num[10:0];
            hdiv_reg[0] <= d6;
            hq_reg[0]   <= '0;
            srem_reg[0] <= dd;
            sdiv_reg[0] <= den;
            sq_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage for hue and saturation
    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic [11:0] htrial;
        logic [8:0]  strial;
        logic        hge, sge;

        always_comb
        begin
            htrial = (j == 0) ? {1'b0, hrem_reg[j]} : {hrem_reg[j], 1'b0};
            strial = (j == 0) ? {1'b0, srem_reg[j]} : {srem_reg[j], 1'b0};
            hge    = htrial >= {1'b0, hdiv_reg[j]};
            sge    = strial >= {1'b0, sdiv_reg[j]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (advance)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_carry_reg[j+1] <= dv_carry_reg[j];
                hdiv_reg[j+1]     <= hdiv_reg[j];
                sdiv_reg[j+1]     <= sdiv_reg[j];
                hrem_reg[j+1]     <= hge ? 11'(htrial - {1'b0, hdiv_reg[j]})
                                         : htrial[10:0];
                srem_reg[j+1]     <= sge ? 8'(strial - {1'b0, sdiv_reg[j]})
                                         : strial[7:0];
                hq_reg[j+1]       <= {hq_reg[j][TW-2:0], hge};
                sq_reg[j+1]       <= {sq_reg[j][TW-2:0], sge};
            end
        end
    end

    // ---------------- stage P1: m = L * s ----------------
    logic              p1_valid_reg;
    lch_carry_t        p1_carry_reg;
    logic [TW-1:0]     p1_l_reg, p1_s_reg, p1_m_reg, p1_h_reg;
    logic [TW-1:0]     lf;
    logic [2*TW-1:0]   ls_prod;

    always_comb
    begin
        lf      = TW'({dv_carry_reg[NDIV].repl, {(FB-8){1'b0}}});
        ls_prod = (2*TW)'(lf) * (2*TW)'(sq_reg[NDIV]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (advance)
            p1_valid_reg <= dv_valid_reg[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_carry_reg <= dv_carry_reg[NDIV];
            p1_l_reg     <= lf;
            p1_s_reg     <= sq_reg[NDIV];
            p1_m_reg     <= ls_prod[FB +: TW];
            p1_h_reg     <= hq_reg[NDIV];
        end
    end

    // ---------------- stage P2: q, p and curve segment ----------------
    logic              p2_valid_reg;
    lch_carry_t        p2_carry_reg;
    logic [TW:0]       p2_q_reg, p2_p_reg, p2_dqp_reg;
    lch_seg_t          p2_seg_reg [3];
    logic [FB+3:0]     p2_f_reg   [3];
    logic [TW:0]       q_c, p_c;
    logic [TW-1:0]     tt   [3];
    lch_seg_t          seg_c [3];
    logic [FB+3:0]     f_c  [3];

    always_comb
    begin
        if (p1_l_reg < FX_HALF)
            q_c = {1'b0, p1_l_reg} + {1'b0, p1_m_reg};
        else
            q_c = {1'b0, p1_l_reg} + {1'b0, p1_s_reg} - {1'b0, p1_m_reg};
        p_c = {p1_l_reg, 1'b0} - q_c;
        // red, green, blue hue offsets with wrap into one turn
        tt[0] = p1_h_reg + FX_THIRD;
        if (tt[0] > FX_ONE)
            tt[0] = tt[0] - FX_ONE;
        tt[1] = p1_h_reg;
        tt[2] = (p1_h_reg >= FX_THIRD) ? (p1_h_reg - FX_THIRD)
                                      : (p1_h_reg + FX_ONE - FX_THIRD);
        for (int c = 0; c < 3; c++)
        begin
            if (tt[c] < FX_SIXTH)
            begin
                seg_c[c] = SEG_RISE;
                f_c[c]   = (FB+4)'(tt[c]) * (FB+4)'(6);
            end
            else if (tt[c] < FX_HALF)
            begin
                seg_c[c] = SEG_HIGH;
                f_c[c]   = '0;
            end
            else if (tt[c] < FX_TWO_THIRDS)
            begin
                seg_c[c] = SEG_FALL;
                f_c[c]   = (FB+4)'(FX_TWO_THIRDS - tt[c]) * (FB+4)'(6);
            end
            else
            begin
                seg_c[c] = SEG_LOW;
                f_c[c]   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (advance)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p2_carry_reg <= p1_carry_reg;
            p2_q_reg     <= q_c;
            p2_p_reg     <= p_c;
            p2_dqp_reg   <= q_c - p_c;
            for (int c = 0; c < 3; c++)
            begin
                p2_seg_reg[c] <= seg_c[c];
                p2_f_reg[c]   <= f_c[c];
            end
        end
    end

    // ---------------- stage P3: curve value per channel ----------------
    logic              p3_valid_reg;
    lch_carry_t        p3_carry_reg;
    logic [FB+6:0]     p3_v_reg [3];
    logic [2*FB+5:0]   cprod [3];
    logic [FB+6:0]     v_c   [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cprod[c] = (2*FB+6)'(p2_dqp_reg) * (2*FB+6)'(p2_f_reg[c]);
            case (p2_seg_reg[c])
                SEG_RISE, SEG_FALL:
                    v_c[c] = (FB+7)'(p2_p_reg) + {1'b0, cprod[c][2*FB+5:FB]};
                SEG_HIGH: v_c[c] = (FB+7)'(p2_q_reg);
                default:  v_c[c] = (FB+7)'(p2_p_reg);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (advance)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p3_carry_reg <= p2_carry_reg;
            for (int c = 0; c < 3; c++)
                p3_v_reg[c] <= v_c[c];
        end
    end

    // ---------------- output stage: scale, saturate, select ----------------
    logic              result_valid_reg;
    lch_result_t       result_reg;
    logic [FB+14:0]    scaled [3];
    logic [7:0]        ch     [3];
    logic [16:0]       gray_prod;
    logic [7:0]        gray_c;
    lch_result_t       result_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            scaled[c] = {p3_v_reg[c], 8'b0} - (FB+15)'(p3_v_reg[c]);
            ch[c] = (scaled[c][FB+14:FB] > 15'd255) ? 8'd255 : scaled[c][FB+7:FB];
        end
        gray_prod = {p3_carry_reg.repl, 8'b0} - {8'b0, p3_carry_reg.repl};
        gray_c    = gray_prod[15:8];
        if (!p3_carry_reg.changed)
            result_next = '{red_out: p3_carry_reg.pixel.red_in,
                            green_out: p3_carry_reg.pixel.green_in,
                            blue_out: p3_carry_reg.pixel.blue_in,
                            was_changed: 1'b0};
        else if (p3_carry_reg.gray)
            result_next = '{red_out: gray_c, green_out: gray_c, blue_out: gray_c,
                            was_changed: 1'b1};
        else
            result_next = '{red_out: ch[0], green_out: ch[1], blue_out: ch[2],
                            was_changed: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    `CHK_NEXT(a_drain, p3_valid_reg && advance, result_valid,
        "pipeline dropped a finished request")
    `CHK_SAME(a_thr_high, dv_valid_reg[0] && (thr_reg > LIGHTNESS_FULL),
        !dv_carry_reg[0].changed, "pixel changed with threshold out of reach")
    `CHK_NEXT(a_hold, p1_valid_reg && !advance, p1_valid_reg && $stable(p1_m_reg),
        "stage moved while stalled")

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
    import lch_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 12;
    localparam longint ONE = longint'(1) << FB;
    localparam longint HALF = ONE / 2;
    localparam longint THIRD = (ONE + 1) / 3;
    localparam longint SIXTH = (ONE + 3) / 6;
    localparam longint TWO_THIRDS = (2 * ONE + 1) / 3;
    localparam int LATENCY = FB + 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic [8:0]  cfg_data;
    logic        pixel_valid;
    logic        pixel_stall;
    lch_pixel_t  pixel;
    logic        result_valid;
    logic        result_stall;
    lch_result_t result;

    lightness_clamp_hsl_core #(.FRACTION_BITS(FB)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Predictor's copy of the registers
    logic [8:0] clamp_threshold;
    logic [8:0] clamp_replacement;

    lch_pixel_t  pending_pixels[$];
    lch_result_t expected_results[$];
    int          idle_pct;
    int          stall_pct;
    int          error_count;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Piece of the hue curve for one channel
    function automatic longint curve_value(longint p, longint q, longint t);
        if (t < 0)
            t += ONE;
        if (t > ONE)
            t -= ONE;
        if (t < SIXTH)
            return p + (((q - p) * 6 * t) >>> FB);
        if (t < HALF)
            return q;
        if (t < TWO_THIRDS)
            return p + (((q - p) * (TWO_THIRDS - t) * 6) >>> FB);
        return p;
    endfunction

    function automatic logic [7:0] channel_of(longint v);
        longint c;
        if (v < 0)
            v = 0;
        c = (v * 255) >>> FB;
        if (c > 255)
            c = 255;
        return c[7:0];
    endfunction

    function automatic lch_result_t clamp_pixel(lch_pixel_t px);
        lch_result_t res;
        longint r, g, b, mx, mn, d, num, den, h, s, lf, m, q, p, repl;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        mx = (r > g) ? r : g;
        if (b > mx)
            mx = b;
        mn = (r < g) ? r : g;
        if (b < mn)
            mn = b;
        if ((mx + mn) * 128 < longint'(clamp_threshold) * 255)
        begin
            res = '{px.red_in, px.green_in, px.blue_in, 1'b0};
            return res;
        end
        repl = (clamp_replacement > 256) ? 256 : clamp_replacement;
        res.was_changed = 1'b1;
        if (mx == mn)
        begin
            res.red_out = 8'((repl * 255) >> 8);
            res.green_out = res.red_out;
            res.blue_out = res.red_out;
            return res;
        end
        d = mx - mn;
        if (mx == r)
            num = (g - b) + ((g < b) ? 6 * d : 0);
        else if (mx == g)
            num = (b - r) + 2 * d;
        else
            num = (r - g) + 4 * d;
        h = (num * ONE) / (6 * d);
        den = (mx + mn > 255) ? (510 - mx - mn) : (mx + mn);
        s = (d * ONE) / den;
        lf = repl << (FB - 8);
        m = (lf * s) >>> FB;
        q = (lf < HALF) ? (lf + m) : (lf + s - m);
        p = 2 * lf - q;
        res.red_out = channel_of(curve_value(p, q, h + THIRD));
        res.green_out = channel_of(curve_value(p, q, h));
        res.blue_out = channel_of(curve_value(p, q, h - THIRD));
        return res;
    endfunction

    // Sender: hold the request until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid <= 1'b0;
            pixel <= '0;
        end
        else if (!pixel_valid || !pixel_stall)
        begin
            if (pixel_valid)
                expected_results = {expected_results, clamp_pixel(pixel)};
            if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                pixel_valid <= 1'b1;
                pixel <= pending_pixels.pop_front();
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    // Receiver: check each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        lch_result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%t: unexpected result %h", $realtime, result);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.red_out !== want.red_out)
                    begin
                        $display("%t: red expected %0d actual %0d", $realtime,
                                 want.red_out, result.red_out);
                        error_count++;
                    end
                    if (result.green_out !== want.green_out)
                    begin
                        $display("%t: green expected %0d actual %0d", $realtime,
                                 want.green_out, result.green_out);
                        error_count++;
                    end
                    if (result.blue_out !== want.blue_out)
                    begin
                        $display("%t: blue expected %0d actual %0d", $realtime,
                                 want.blue_out, result.blue_out);
                        error_count++;
                    end
                    if (result.was_changed !== want.was_changed)
                    begin
                        $display("%t: changed flag expected %0d actual %0d", $realtime,
                                 want.was_changed, result.was_changed);
                        error_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic lch_pixel_t rand_pixel();
        lch_pixel_t px;
        int base;
        case ($urandom_range(3))
            0: px = 24'($urandom);
            1:
            begin
                base = $urandom_range(255);
                px = '{8'(base), 8'(base), 8'(base)};
            end
            2:
            begin
                base = $urandom_range(200, 255);
                px = '{8'($urandom_range(base, 255)), 8'($urandom_range(base, 255)),
                       8'($urandom_range(base, 255))};
            end
            default:
            begin
                base = $urandom_range(255);
                px = '{8'(base), 8'($urandom_range(255)), 8'(base)};
            end
        endcase
        return px;
    endfunction

    // Append one pixel to the sender's queue
    task automatic queue_pixel(lch_pixel_t px);
        pending_pixels = {pending_pixels, px};
    endtask

    // Drain all outstanding requests, then let the pipeline settle
    task automatic drain_pipeline();
        while (pending_pixels.size() != 0 || pixel_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [8:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_THRESHOLD)
            clamp_threshold = value;
        else
            clamp_replacement = value;
        @(posedge clk);
    endtask

    task automatic run_phase(int count, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) queue_pixel(rand_pixel());
        drain_pipeline();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        clamp_threshold = THRESHOLD_RESET;
        clamp_replacement = REPLACEMENT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: white reaches threshold one exactly
        queue_pixel('{8'd255, 8'd255, 8'd255});
        queue_pixel('{8'd255, 8'd255, 8'd254});
        queue_pixel('{8'd0, 8'd0, 8'd0});
        drain_pipeline();

        // Threshold zero: every pixel changes, directed corners
        write_register(CFG_THRESHOLD, 9'd0);
        write_register(CFG_REPLACEMENT, 9'd128);
        queue_pixel('{8'd0, 8'd0, 8'd0});
        queue_pixel('{8'd255, 8'd0, 8'd0});
        queue_pixel('{8'd0, 8'd255, 8'd0});
        queue_pixel('{8'd0, 8'd0, 8'd255});
        queue_pixel('{8'd255, 8'd255, 8'd0});
        queue_pixel('{8'd0, 8'd255, 8'd255});
        queue_pixel('{8'd255, 8'd0, 8'd255});
        queue_pixel('{8'd10, 8'd5, 8'd200});
        queue_pixel('{8'd200, 8'd10, 8'd50});
        queue_pixel('{8'd128, 8'd127, 8'd127});
        queue_pixel('{8'd170, 8'd85, 8'd85});
        drain_pipeline();

        // Replacement above full scale saturates to white; also full scale
        write_register(CFG_REPLACEMENT, 9'd511);
        queue_pixel('{8'd12, 8'd240, 8'd99});
        queue_pixel('{8'd77, 8'd77, 8'd77});
        drain_pipeline();
        write_register(CFG_REPLACEMENT, 9'd256);
        queue_pixel('{8'd12, 8'd240, 8'd99});
        drain_pipeline();

        // Threshold above full scale: nothing changes
        write_register(CFG_THRESHOLD, 9'd511);
        queue_pixel('{8'd255, 8'd255, 8'd255});
        queue_pixel('{8'd255, 8'd0, 8'd255});
        drain_pipeline();

        // Random phases across register settings, idling and stall patterns
        write_register(CFG_THRESHOLD, 9'd128);
        write_register(CFG_REPLACEMENT, 9'd0);
        run_phase(200, 0, 0);
        write_register(CFG_THRESHOLD, 9'(200));
        write_register(CFG_REPLACEMENT, 9'd200);
        run_phase(250, 83, 0);
        write_register(CFG_THRESHOLD, 9'($urandom_range(0, 511)));
        write_register(CFG_REPLACEMENT, 9'($urandom_range(0, 511)));
        run_phase(250, 0, 83);
        write_register(CFG_THRESHOLD, 9'($urandom_range(0, 256)));
        write_register(CFG_REPLACEMENT, 9'($urandom_range(0, 256)));
        run_phase(250, 15, 15);
        write_register(CFG_THRESHOLD, 9'd0);
        write_register(CFG_REPLACEMENT, 9'($urandom_range(0, 511)));
        run_phase(250, 0, 0);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
